// ===== hw/rtl/otc_pkg.sv =====
`timescale 1ns / 1ps

package otc_pkg;

    // Fixed field widths of the channels and the register
    localparam int TRIM_FIELD_W = 8;
    localparam int MEAS_FIELD_W = 16;
    localparam int CFG_W        = 16;

    // Target frame length after reset
    localparam logic [CFG_W-1:0] TARGET_RESET = 16'd2356;

    // Number of neighbor trials: base-1, base, base+1
    localparam int NEIGH_TRIALS = 3;

    // Calibration phase
    typedef enum logic [1:0] {
        PH_IDLE   = 2'd0,
        PH_SEARCH = 2'd1,
        PH_NEIGH  = 2'd2
    } phase_t;

endpackage

// ===== hw/rtl/otc_step.sv =====
`timescale 1ns / 1ps

// Next-state and result logic for one accepted item
module otc_step #(
    parameter int TRIM_BITS    = 8,
    parameter int MEASURE_BITS = 16
) (
    input  otc_pkg::phase_t          phase,
    input  logic [TRIM_BITS-1:0]     search_step,
    input  logic [TRIM_BITS-1:0]     trial_base,
    input  logic [TRIM_BITS-1:0]     candidate,
    input  logic [TRIM_BITS-1:0]     best_trim,
    input  logic [MEASURE_BITS-1:0]  best_deviation,
    input  logic                     start,
    input  logic [MEASURE_BITS-1:0]  meas,
    input  logic [MEASURE_BITS-1:0]  target,
    output otc_pkg::phase_t          phase_next,
    output logic [TRIM_BITS-1:0]     search_step_next,
    output logic [TRIM_BITS-1:0]     trial_base_next,
    output logic [TRIM_BITS-1:0]     candidate_next,
    output logic [TRIM_BITS-1:0]     best_trim_next,
    output logic [MEASURE_BITS-1:0]  best_deviation_next,
    output logic [TRIM_BITS-1:0]     trim,
    output logic                     done
);

    localparam logic [TRIM_BITS-1:0] TRIM_MAX  = {TRIM_BITS{1'b1}};
    localparam logic [TRIM_BITS-1:0] STEP_TOP  = {1'b1, {(TRIM_BITS-1){1'b0}}};
    localparam logic [TRIM_BITS-1:0] NEIGH_END = TRIM_BITS'(otc_pkg::NEIGH_TRIALS);

    // base-1+k, clamped at both ends of the trim range
    function automatic logic [TRIM_BITS-1:0] neighbor(input logic [TRIM_BITS-1:0] b,
                                                      input logic [1:0] k);
        logic [TRIM_BITS-1:0] r;
        case (k)
            2'd0:    r = (b == '0) ? '0 : b - 1'b1;
            2'd1:    r = b;
            default: r = (b == TRIM_MAX) ? TRIM_MAX : b + 1'b1;
        endcase
        return r;
    endfunction

    logic [TRIM_BITS-1:0]    base_sum;
    logic [TRIM_BITS-1:0]    step_shift;
    logic [TRIM_BITS-1:0]    trial_count;
    logic [MEASURE_BITS-1:0] deviation;

    assign base_sum    = trial_base + search_step;
    assign step_shift  = search_step >> 1;
    assign trial_count = search_step + 1'b1;
    assign deviation   = (meas >= target) ? meas - target : target - meas;

    // Next state
    always_comb
    begin
        phase_next          = phase;
        search_step_next    = search_step;
        trial_base_next     = trial_base;
        candidate_next      = candidate;
        best_trim_next      = best_trim;
        best_deviation_next = best_deviation;
        if (start)
        begin
            phase_next       = otc_pkg::PH_SEARCH;
            search_step_next = STEP_TOP;
            trial_base_next  = '0;
        end
        else
        begin
            case (phase)
                otc_pkg::PH_SEARCH:
                begin
                    // keep the step bit when the clock ran slow
                    if (meas < target)
                        trial_base_next = base_sum;
                    search_step_next = step_shift;
                    if (step_shift == '0)
                    begin
                        best_trim_next      = trial_base_next;
                        best_deviation_next = meas;
                        phase_next          = otc_pkg::PH_NEIGH;
                        candidate_next      = neighbor(trial_base_next, 2'd0);
                    end
                end
                otc_pkg::PH_NEIGH:
                begin
                    if (deviation < best_deviation)
                    begin
                        best_deviation_next = deviation;
                        best_trim_next      = candidate;
                    end
                    if (trial_count >= NEIGH_END)
                    begin
                        search_step_next = '0;
                        phase_next       = otc_pkg::PH_IDLE;
                    end
                    else
                    begin
                        search_step_next = trial_count;
                        candidate_next   = neighbor(trial_base, trial_count[1:0]);
                    end
                end
                default:
                begin
                    phase_next = otc_pkg::PH_IDLE;
                end
            endcase
        end
    end

    // Result item
    always_comb
    begin
        trim = best_trim;
        done = 1'b0;
        if (start)
        begin
            trim = STEP_TOP;
        end
        else
        begin
            case (phase)
                otc_pkg::PH_SEARCH:
                begin
                    if (step_shift != '0)
                        trim = trial_base_next + step_shift;
                    else
                        trim = candidate_next;
                end
                otc_pkg::PH_NEIGH:
                begin
                    if (trial_count >= NEIGH_END)
                    begin
                        trim = best_trim_next;
                        done = 1'b1;
                    end
                    else
                    begin
                        trim = candidate_next;
                    end
                end
                default:
                begin
                    trim = best_trim;
                end
            endcase
        end
    end

endmodule

// ===== hw/rtl/oscillator_trim_calibrator.sv =====
`timescale 1ns / 1ps

// Oscillator trim calibrator. Each input item gives one result item in the cycle
// after it is accepted, and a new item is taken in every cycle: the state
// update and the result come from one short pass of compare and add logic
// into the state and result registers. The input stalls only while a result
// is held under out_stall; an edge at which the held result leaves also takes
// the next item, so the only throttle is a stalled result that cannot yet move.
// A start item begins a calibration
// whose results propose the trim to try next; after TRIM_BITS search items
// and three neighbor items the result carries done_res with the chosen trim.
// Items without start while idle return the last chosen trim. target_length
// is written through the cfg port, which is always ready.
module oscillator_trim_calibrator #(
    parameter int TRIM_BITS    = 8,
    parameter int MEASURE_BITS = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // input items
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic                              start_req,
    input  logic [otc_pkg::MEAS_FIELD_W-1:0]  measured_length,
    // result items
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [otc_pkg::TRIM_FIELD_W-1:0]  osc_trim,
    output logic                              done_res,
    // target_length register write
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [otc_pkg::CFG_W-1:0]         cfg_data
);

    otc_pkg::phase_t          phase_reg, phase_next;
    logic [TRIM_BITS-1:0]     search_step_reg, search_step_next;
    logic [TRIM_BITS-1:0]     trial_base_reg, trial_base_next;
    logic [TRIM_BITS-1:0]     candidate_reg, candidate_next;
    logic [TRIM_BITS-1:0]     best_trim_reg, best_trim_next;
    logic [MEASURE_BITS-1:0]  best_deviation_reg, best_deviation_next;
    logic [otc_pkg::CFG_W-1:0] target_reg;

    logic                              out_valid_reg;
    logic [otc_pkg::TRIM_FIELD_W-1:0]  out_trim_reg;
    logic                              out_done_reg;

    logic                     accept;
    logic [TRIM_BITS-1:0]     trim;
    logic                     done;
    logic [MEASURE_BITS-1:0]  meas;
    logic [MEASURE_BITS-1:0]  target;

    // handshake: stall only while a result is held
    assign in_stall  = out_valid_reg && out_stall;
    assign accept    = in_valid && !in_stall;
    assign cfg_ready = 1'b1;

    assign meas   = MEASURE_BITS'(measured_length);
    assign target = MEASURE_BITS'(target_reg);

    otc_step #(
        .TRIM_BITS    (TRIM_BITS),
        .MEASURE_BITS (MEASURE_BITS)
    ) u_step (
        .phase               (phase_reg),
        .search_step         (search_step_reg),
        .trial_base          (trial_base_reg),
        .candidate           (candidate_reg),
        .best_trim           (best_trim_reg),
        .best_deviation      (best_deviation_reg),
        .start               (start_req),
        .meas                (meas),
        .target              (target),
        .phase_next          (phase_next),
        .search_step_next    (search_step_next),
        .trial_base_next     (trial_base_next),
        .candidate_next      (candidate_next),
        .best_trim_next      (best_trim_next),
        .best_deviation_next (best_deviation_next),
        .trim                (trim),
        .done                (done)
    );

    // config register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            target_reg <= otc_pkg::TARGET_RESET;
        else if (cfg_valid && cfg_ready)
            target_reg <= cfg_data;
    end

    // calibration state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg          <= otc_pkg::PH_IDLE;
            search_step_reg    <= '0;
            trial_base_reg     <= '0;
            candidate_reg      <= '0;
            best_trim_reg      <= '0;
            best_deviation_reg <= '1;
        end
        else if (accept)
        begin
            phase_reg          <= phase_next;
            search_step_reg    <= search_step_next;
            trial_base_reg     <= trial_base_next;
            candidate_reg      <= candidate_next;
            best_trim_reg      <= best_trim_next;
            best_deviation_reg <= best_deviation_next;
        end
    end

    // result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (accept)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_trim_reg <= otc_pkg::TRIM_FIELD_W'(trim);
            out_done_reg <= done;
        end
    end

    assign out_valid = out_valid_reg;
    assign osc_trim  = out_trim_reg;
    assign done_res  = out_done_reg;

endmodule

// ===== hw/rtl/otc_checker.sv =====
`timescale 1ns / 1ps

// Port-level checks for the trim calibrator
module otc_checker #(
    parameter int TRIM_BITS    = 8
) (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              in_valid,
    input logic                              in_stall,
    input logic                              start_req,
    input logic                              out_valid,
    input logic                              out_stall,
    input logic [otc_pkg::TRIM_FIELD_W-1:0]  osc_trim,
    input logic                              done_res
);

    localparam logic [otc_pkg::TRIM_FIELD_W-1:0] FIRST_TRIAL =
        otc_pkg::TRIM_FIELD_W'(1 << (TRIM_BITS - 1));

    // a held result keeps its payload
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(osc_trim) && $stable(done_res))
        else $error("stalled result changed");

    // input side stalls only behind a waiting result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled with no result waiting");

    // every accepted item shows a result in the next cycle
    a_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> out_valid)
        else $error("accepted item gave no result");

    // a start item proposes the top search bit and is never done
    a_start: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && start_req |=> !done_res && osc_trim == FIRST_TRIAL)
        else $error("start item gave a wrong first trial");

endmodule

bind oscillator_trim_calibrator otc_checker #(
    .TRIM_BITS    (TRIM_BITS)
) u_otc_checker (.*);

// ===== tb/oscillator_trim_calibrator_test.sv =====
`timescale 1ns / 1ps

module oscillator_trim_calibrator_test;

    localparam int TRIM_MAX      = (1 << otc_pkg::TRIM_FIELD_W) - 1;
    localparam int MEAS_MAX      = (1 << otc_pkg::MEAS_FIELD_W) - 1;
    localparam int RANDOM_ITEMS  = 900;
    localparam int SETTING_COUNT = 8;
    localparam int CYCLE_LIMIT   = 1000000;

    typedef struct packed {
        logic [otc_pkg::TRIM_FIELD_W-1:0] trim;
        logic                             done;
    } trim_result_t;

    // Tracks the calibration state and holds the trims still owed by the block
    class trim_scoreboard;
        otc_pkg::phase_t                  phase;
        logic [otc_pkg::TRIM_FIELD_W-1:0] step;
        logic [otc_pkg::TRIM_FIELD_W-1:0] base;
        logic [otc_pkg::TRIM_FIELD_W-1:0] cand;
        logic [otc_pkg::TRIM_FIELD_W-1:0] best;
        logic [otc_pkg::MEAS_FIELD_W-1:0] best_dev;
        logic [otc_pkg::CFG_W-1:0]        target;
        trim_result_t                     trims_due[$];
        int                               errors;

        function new();
            target   = otc_pkg::TARGET_RESET;
            phase    = otc_pkg::PH_IDLE;
            step     = '0;
            base     = '0;
            cand     = '0;
            best     = '0;
            best_dev = '1;
            errors   = 0;
        endfunction

        function void set_target(logic [otc_pkg::CFG_W-1:0] v);
            target = v;
        endfunction

        // base - 1 + k, held inside the trim range
        function logic [otc_pkg::TRIM_FIELD_W-1:0] neighbor_trim(int k);
            int v;
            v = int'(base) + k - 1;
            if (v < 0)
                v = 0;
            if (v > TRIM_MAX)
                v = TRIM_MAX;
            return v[otc_pkg::TRIM_FIELD_W-1:0];
        endfunction

        // Advance the calibration by one accepted item and queue its result
        function void note_measurement(logic s, logic [otc_pkg::MEAS_FIELD_W-1:0] m);
            trim_result_t                     r;
            logic [otc_pkg::MEAS_FIELD_W-1:0] dev;
            r.trim = best;
            r.done = 1'b0;
            if (s)
            begin
                phase  = otc_pkg::PH_SEARCH;
                step   = otc_pkg::TRIM_FIELD_W'(1 << (otc_pkg::TRIM_FIELD_W - 1));
                base   = '0;
                r.trim = base + step;
            end
            else if (phase == otc_pkg::PH_SEARCH)
            begin
                // a short frame means the clock is slow: keep the bit
                if (m < target)
                    base = base + step;
                step = step >> 1;
                if (step != 0)
                    r.trim = base + step;
                else
                begin
                    best     = base;
                    best_dev = m;
                    phase    = otc_pkg::PH_NEIGH;
                    cand     = neighbor_trim(0);
                    r.trim   = cand;
                end
            end
            else if (phase == otc_pkg::PH_NEIGH)
            begin
                dev = (m >= target) ? m - target : target - m;
                if (dev < best_dev)
                begin
                    best_dev = dev;
                    best     = cand;
                end
                step = step + 1'b1;
                if (step >= otc_pkg::NEIGH_TRIALS)
                begin
                    step   = '0;
                    phase  = otc_pkg::PH_IDLE;
                    r.trim = best;
                    r.done = 1'b1;
                end
                else
                begin
                    cand   = neighbor_trim(int'(step));
                    r.trim = cand;
                end
            end
            else
                phase = otc_pkg::PH_IDLE;
            trims_due.push_back(r);
        endfunction

        function void check_result(logic [otc_pkg::TRIM_FIELD_W-1:0] t, logic d);
            trim_result_t e;
            if (trims_due.size() == 0)
            begin
                $display("%0t: unexpected item osc_trim=%0d done_res=%0d", $time, t, d);
                errors++;
                return;
            end
            e = trims_due.pop_front();
            if (t !== e.trim)
            begin
                $display("%0t: osc_trim expected %0d, got %0d", $time, e.trim, t);
                errors++;
            end
            if (d !== e.done)
            begin
                $display("%0t: done_res expected %0d, got %0d", $time, e.done, d);
                errors++;
            end
        endfunction

        function int pending();
            return trims_due.size();
        endfunction

        function void finish();
            if (trims_due.size() != 0)
            begin
                $display("%0t: %0d result items never arrived", $time, trims_due.size());
                errors++;
            end
        endfunction
    endclass

    logic                             clk;
    logic                             rst_n           = 1'b0;
    logic                             in_valid        = 1'b0;
    logic                             in_stall;
    logic                             start_req       = 1'b0;
    logic [otc_pkg::MEAS_FIELD_W-1:0] measured_length = '0;
    logic                             out_valid;
    logic                             out_stall       = 1'b0;
    logic [otc_pkg::TRIM_FIELD_W-1:0] osc_trim;
    logic                             done_res;
    logic                             cfg_valid       = 1'b0;
    logic                             cfg_ready;
    logic [otc_pkg::CFG_W-1:0]        cfg_data        = '0;

    trim_scoreboard sb = new();

    int burst_left = 0;
    int stall_left = 0;
    int free_left  = 0;
    int items_done = 0;

    oscillator_trim_calibrator i_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .start_req       (start_req),
        .measured_length (measured_length),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .osc_trim        (osc_trim),
        .done_res        (done_res),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_data        (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(0, 2);
        else if (r < 95)
            return $urandom_range(3, 8);
        return $urandom_range(20, 60);
    endfunction

    // Random length over the whole field
    function automatic logic [otc_pkg::MEAS_FIELD_W-1:0] any_length();
        return otc_pkg::MEAS_FIELD_W'($urandom_range(0, MEAS_MAX));
    endfunction

    // Frame length near the target, far off, or at the ends of the range
    function automatic logic [otc_pkg::MEAS_FIELD_W-1:0] pick_length(
        logic [otc_pkg::CFG_W-1:0] tgt);
        int r;
        int v;
        r = $urandom_range(0, 99);
        if (r < 55)
            v = int'(tgt) + int'($urandom_range(0, 8)) - 4;
        else if (r < 75)
            v = int'(tgt) + int'($urandom_range(0, 400)) - 200;
        else if (r < 90)
            v = int'($urandom_range(0, MEAS_MAX));
        else if (r < 95)
            v = 0;
        else
            v = MEAS_MAX;
        if (v < 0)
            v = 0;
        if (v > MEAS_MAX)
            v = MEAS_MAX;
        return v[otc_pkg::MEAS_FIELD_W-1:0];
    endfunction

    // Watch both channels; each result comes out after its item, later when stalled
    always @(posedge clk)
    begin
        if (in_valid && !in_stall)
            sb.note_measurement(start_req, measured_length);
        if (out_valid && !out_stall)
            sb.check_result(osc_trim, done_res);
    end

    // Result side back-pressure, with stretches of none
    always @(posedge clk)
    begin
        if (stall_left == 0 && free_left == 0)
        begin
            stall_left = pick_gap();
            free_left  = ($urandom_range(0, 9) == 0) ? int'($urandom_range(50, 200))
                                                      : int'($urandom_range(0, 12));
        end
        if (stall_left > 0)
        begin
            stall_left--;
            out_stall <= 1'b1;
        end
        else
        begin
            if (free_left > 0)
                free_left--;
            out_stall <= 1'b0;
        end
    end

    // Offer one item and hold it until taken, then maybe leave a gap
    task automatic send_item(logic s, logic [otc_pkg::MEAS_FIELD_W-1:0] m);
        int gap;
        if (!in_valid)
            in_valid <= 1'b1;
        start_req       <= s;
        measured_length <= m;
        do
            @(posedge clk);
        while (in_stall);
        if (burst_left > 0)
        begin
            burst_left--;
            gap = 0;
        end
        else
        begin
            gap = pick_gap();
            if ($urandom_range(0, 19) == 0)
                burst_left = int'($urandom_range(20, 80));
        end
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Stop sending and wait until every owed result has come out
    task automatic drain();
        if (in_valid)
            in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic write_target(logic [otc_pkg::CFG_W-1:0] v);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        sb.set_target(v);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // One calibration; sometimes cut short so the next start abandons it
    task automatic run_calibration(logic [otc_pkg::CFG_W-1:0] tgt);
        int n;
        n = ($urandom_range(0, 9) == 0) ? int'($urandom_range(0, 10))
                                        : otc_pkg::TRIM_FIELD_W + otc_pkg::NEIGH_TRIALS;
        send_item(1'b1, any_length());
        items_done++;
        for (int i = 0; i < n; i++)
        begin
            send_item(1'b0, pick_length(tgt));
            items_done++;
        end
    endtask

    initial
    begin
        logic [otc_pkg::CFG_W-1:0] tgt;
        int                        quota;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Idle item after reset returns trim 0
        send_item(1'b0, 16'hFFFF);
        // Short search frames: search runs to the top, neighbors clamp high,
        // and no neighbor beats the seeded deviation of zero
        send_item(1'b1, 16'h0000);
        repeat (otc_pkg::TRIM_FIELD_W) send_item(1'b0, 16'h0000);
        send_item(1'b0, 16'h0000);
        send_item(1'b0, otc_pkg::TARGET_RESET + 16'd1);
        send_item(1'b0, otc_pkg::TARGET_RESET - 16'd1);
        // A fresh calibration, then a start in its middle abandons it
        send_item(1'b1, 16'hFFFF);
        send_item(1'b0, 16'hFFFF);
        send_item(1'b0, 16'hFFFF);
        // Long search frames: search runs to zero, neighbors clamp low
        send_item(1'b1, 16'h0000);
        repeat (otc_pkg::TRIM_FIELD_W) send_item(1'b0, 16'hFFFF);
        send_item(1'b0, otc_pkg::TARGET_RESET);
        send_item(1'b0, otc_pkg::TARGET_RESET);
        send_item(1'b0, otc_pkg::TARGET_RESET + 16'd40);
        send_item(1'b0, 16'h1234);

        // Random calibrations over several target settings
        for (int k = 0; k < SETTING_COUNT; k++)
        begin
            case (k)
                0: tgt = '0;
                1: tgt = '1;
                2: tgt = 16'd1;
                3: tgt = otc_pkg::TARGET_RESET;
                4: tgt = 16'hFFFE;
                default: tgt = otc_pkg::CFG_W'($urandom_range(0, MEAS_MAX));
            endcase
            drain();
            write_target(tgt);
            quota = (k + 1) * RANDOM_ITEMS / SETTING_COUNT;
            while (items_done < quota)
            begin
                case ($urandom_range(0, 19))
                    0:
                    begin
                        send_item(1'b0, any_length());
                        items_done++;
                    end
                    1:
                    begin
                        send_item(1'b1, any_length());
                        items_done++;
                    end
                    2: drain();
                    default: run_calibration(tgt);
                endcase
            end
        end

        drain();
        sb.finish();
        if (sb.errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // Hard stop if the block hangs
    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
